### hdl/rrs_pkg.sv
// Shared widths, codes and bundle types for the round-robin scheduler.
`timescale 1ns / 1ps

package rrs_pkg;

   localparam int ID_W          = 3;
   localparam int NUM_IDS       = 2 ** ID_W;
   localparam int SVC_W         = 8;
   localparam int QUANTUM_W     = 8;
   localparam int SLICE_W       = 8;
   localparam int DEF_NUM_JOBS  = 8;
   localparam logic [QUANTUM_W-1:0] DEF_QUANTUM = 8'd2;
   localparam logic [SLICE_W-1:0]   SLICE_MAX   = '1;
   localparam int REQ_DATA_W    = 16;
   localparam int RSP_DATA_W    = 8;

   typedef enum logic {
      REQ_ARRIVE = 1'b0,
      REQ_TICK   = 1'b1
   } req_kind_type;

   typedef struct packed {
      logic            push;
      logic            pop;
      logic [ID_W-1:0] push_id;
   } q_ctrl_type;

   typedef struct packed {
      logic            empty;
      logic            full;
      logic [ID_W-1:0] head_id;
   } q_stat_type;

   typedef struct packed {
      logic            busy;
      logic [ID_W-1:0] job;
      logic            done;
   } result_type;

endpackage

### hdl/round_robin_scheduler.sv
// Top level of the round-robin job scheduler with a time quantum.
`timescale 1ns / 1ps
//
// Usage:
//   req_* beats carry either a job arrival (req_tuser low: job id and service
//   time in req_tdata) or one time tick (req_tuser high, req_tdata ignored).
//   Arrivals with zero service time, an id of NUM_JOBS or more, or a full
//   ready queue are dropped. Arrivals produce no rsp beat.
//   Every tick produces exactly one rsp beat: rsp_tuser high when a job ran,
//   with its id and a done flag in rsp_tdata; low and zero data when idle.
//   csr_* writes the quantum; write it only while the block is idle.
// Timing:
//   One beat is accepted per cycle while req_tready is high. A tick's result
//   appears on rsp_* the cycle after acceptance, from a single output
//   register; the whole decision is one pass of logic off the state
//   registers and the ready queue's registered head read.
// Reset and stalls:
//   Reset empties the queue, stops any running job and sets quantum to 2.
//   While a result waits and rsp_tready is low, req_tready drops; it stays
//   high whenever the output register is empty or being drained.

module round_robin_scheduler
   import rrs_pkg::*;
#(
   parameter int NUM_JOBS = DEF_NUM_JOBS
) (
   input  logic                  clock,
   input  logic                  reset,
   // req_tdata: [2:0] arriving_job, [10:3] service_time, [15:11] zero
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // req_tuser: [0] req_type
   input  logic                  req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // rsp_tdata: [2:0] served_job, [3] job_done, [7:4] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // rsp_tuser: [0] busy_res
   output logic                  rsp_tuser,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [QUANTUM_W-1:0]  csr_data
);

   logic [QUANTUM_W-1:0] quantum_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   result_type           rsp_res_ff;
   logic                 fire;
   logic                 res_valid;
   result_type           result;
   q_ctrl_type           q_ctrl;
   q_stat_type           q_stat;

   // Take a beat whenever the output register is free or emptying.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign fire       = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         quantum_ff <= DEF_QUANTUM;
      end else if (csr_valid && csr_ready) begin
         quantum_ff <= csr_data;
      end
   end

   rrs_ready_queue #(
      .NUM_JOBS (NUM_JOBS)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .ctrl  (q_ctrl),
      .stat  (q_stat)
   );

   rrs_sched #(
      .NUM_JOBS (NUM_JOBS)
   ) u_sched (
      .clock        (clock),
      .reset        (reset),
      .fire         (fire),
      .kind         (req_kind_type'(req_tuser)),
      .arriving_job (req_tdata[ID_W-1:0]),
      .service_time (req_tdata[ID_W+SVC_W-1:ID_W]),
      .quantum      (quantum_ff),
      .q_stat       (q_stat),
      .q_ctrl       (q_ctrl),
      .res_valid    (res_valid),
      .result       (result)
   );

   // Load a new result on a tick; drop the held one once taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (res_valid) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid) begin
         rsp_res_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_res_ff.busy;
   assign rsp_tdata  = {(RSP_DATA_W - ID_W - 1)'(0), rsp_res_ff.done, rsp_res_ff.job};

`ifndef ASSERT_OFF
   a_tick_gives_beat: assert property (@(posedge clock) disable iff (reset)
      (fire && req_tuser == REQ_TICK) |=> rsp_tvalid)
      else $error("tick accepted without a result beat");
   a_arrival_no_beat: assert property (@(posedge clock) disable iff (reset)
      (fire && req_tuser == REQ_ARRIVE && rsp_tready) |=> !rsp_tvalid)
      else $error("arrival produced a result beat");
   a_idle_is_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata == '0))
      else $error("idle result carries data");
`endif

endmodule

### hdl/rrs_ready_queue.sv
// Circular ready queue of job ids with a registered head read.
`timescale 1ns / 1ps

module rrs_ready_queue
   import rrs_pkg::*;
#(
   parameter int NUM_JOBS = DEF_NUM_JOBS
) (
   input  logic       clock,
   input  logic       reset,
   input  q_ctrl_type ctrl,
   output q_stat_type stat
);

   localparam int QW = $clog2(NUM_JOBS);
   localparam int CW = $clog2(NUM_JOBS + 1);

   logic [ID_W-1:0] mem [NUM_JOBS];
   logic [QW-1:0]   head_ff, head_in;
   logic [CW-1:0]   count_ff, count_in;
   logic [ID_W-1:0] head_id_ff;
   logic [QW:0]     tail_sum;
   logic [QW-1:0]   tail;
   logic [QW-1:0]   head_inc;

   // Tail slot is head + count, wrapped once.
   assign tail_sum = (QW + 1)'(head_ff) + (QW + 1)'(count_ff);
   assign tail     = (tail_sum >= (QW + 1)'(NUM_JOBS)) ?
                     QW'(tail_sum - (QW + 1)'(NUM_JOBS)) : QW'(tail_sum);
   assign head_inc = (head_ff == QW'(NUM_JOBS - 1)) ? '0 : head_ff + 1'b1;

   always_comb begin
      head_in  = ctrl.pop ? head_inc : head_ff;
      count_in = count_ff;
      if (ctrl.push && !ctrl.pop) begin
         count_in = count_ff + 1'b1;
      end else if (ctrl.pop && !ctrl.push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   // Write at the tail; read the slot that will be the head next cycle,
   // forwarding a write that lands there.
   always_ff @(posedge clock) begin
      if (ctrl.push) begin
         mem[tail] <= ctrl.push_id;
      end
      if (ctrl.push && tail == head_in) begin
         head_id_ff <= ctrl.push_id;
      end else begin
         head_id_ff <= mem[head_in];
      end
   end

   assign stat.empty   = (count_ff == '0);
   assign stat.full    = (count_ff == CW'(NUM_JOBS));
   assign stat.head_id = head_id_ff;

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(NUM_JOBS))
      else $error("ready queue count beyond depth");
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (ctrl.push && !ctrl.pop) |-> !stat.full)
      else $error("push into full ready queue");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      ctrl.pop |-> !stat.empty)
      else $error("pop from empty ready queue");
`endif

endmodule

### hdl/rrs_sched.sv
// Slice control: remaining times, running job and per-tick result.
`timescale 1ns / 1ps

module rrs_sched
   import rrs_pkg::*;
#(
   parameter int NUM_JOBS = DEF_NUM_JOBS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fire,
   input  req_kind_type         kind,
   input  logic [ID_W-1:0]      arriving_job,
   input  logic [SVC_W-1:0]     service_time,
   input  logic [QUANTUM_W-1:0] quantum,
   input  q_stat_type           q_stat,
   output q_ctrl_type           q_ctrl,
   output logic                 res_valid,
   output result_type           result
);

   logic [SVC_W-1:0]   rem_ff [NUM_IDS];
   logic [ID_W-1:0]    cur_job_ff, cur_job_in;
   logic               cur_valid_ff, cur_valid_in;
   logic [SLICE_W-1:0] slice_ff, slice_in;

   logic               tick, arrive_ok, boundary, idle_empty, run, requeue;
   logic [ID_W-1:0]    sel_job;
   logic [SVC_W-1:0]   rem_sel;

   assign tick       = fire && (kind == REQ_TICK);
   assign arrive_ok  = fire && (kind == REQ_ARRIVE) && (service_time != '0) &&
                       (32'(arriving_job) < NUM_JOBS) && !q_stat.full;
   assign boundary   = !cur_valid_ff || (slice_ff >= quantum);
   assign idle_empty = boundary && !cur_valid_ff && q_stat.empty;
   assign sel_job    = (boundary && !q_stat.empty) ? q_stat.head_id : cur_job_ff;
   assign rem_sel    = rem_ff[sel_job];
   assign run        = tick && !idle_empty && (rem_sel != '0);
   assign requeue    = tick && boundary && cur_valid_ff && !q_stat.empty;

   always_comb begin
      q_ctrl.pop     = tick && boundary && !q_stat.empty;
      q_ctrl.push    = arrive_ok || requeue;
      q_ctrl.push_id = requeue ? cur_job_ff : arriving_job;
   end

   always_comb begin
      cur_job_in   = cur_job_ff;
      cur_valid_in = cur_valid_ff;
      slice_in     = slice_ff;
      if (tick && !idle_empty) begin
         cur_job_in   = sel_job;
         cur_valid_in = run && (rem_sel != SVC_W'(1));
         if (!run) begin
            slice_in = '0;
         end else if (boundary) begin
            slice_in = SLICE_W'(1);
         end else if (slice_ff != SLICE_MAX) begin
            slice_in = slice_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_job_ff   <= '0;
         cur_valid_ff <= 1'b0;
         slice_ff     <= '0;
      end else begin
         cur_job_ff   <= cur_job_in;
         cur_valid_ff <= cur_valid_in;
         slice_ff     <= slice_in;
      end
   end

   always_ff @(posedge clock) begin
      if (arrive_ok) begin
         rem_ff[arriving_job] <= service_time;
      end else if (run) begin
         rem_ff[sel_job] <= rem_sel - 1'b1;
      end
   end

   assign res_valid   = tick;
   assign result.busy = run;
   assign result.job  = run ? sel_job : '0;
   assign result.done = run && (rem_sel == SVC_W'(1));

`ifndef ASSERT_OFF
   a_running_has_work: assert property (@(posedge clock) disable iff (reset)
      cur_valid_ff |-> (rem_ff[cur_job_ff] != '0))
      else $error("running job has no time left");
   a_done_drops_job: assert property (@(posedge clock) disable iff (reset)
      (tick && result.done) |=> !cur_valid_ff)
      else $error("finished job still marked running");
   a_slice_starts: assert property (@(posedge clock) disable iff (reset)
      (tick && run && boundary) |=> (slice_ff == SLICE_W'(1)))
      else $error("new slice did not start at one");
`endif

endmodule

### verif/testbench.sv
// Self-checking testbench for the round-robin job scheduler.
`timescale 1ns / 1ps

module testbench;
   import rrs_pkg::*;

   localparam int NUM_JOBS = DEF_NUM_JOBS;
   localparam int MAX_SHOWN = 10;

   // One row of the directed stimulus table; the want_* fields hold a typed
   // expectation only where the row marks it, else the predictor decides.
   typedef struct {
      req_kind_type    kind;
      logic [ID_W-1:0] job_id;
      logic [SVC_W-1:0] svc;
      logic            typed;
      logic            want_busy;
      logic [ID_W-1:0] want_job;
      logic            want_done;
   } stim_row_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // req_tdata: [2:0] arriving_job, [10:3] service_time, [15:11] zero
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   // req_tuser: [0] req_type
   logic                  req_tuser  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b1;
   // rsp_tdata: [2:0] served_job, [3] job_done, [7:4] zero
   logic [RSP_DATA_W-1:0] rsp_tdata;
   // rsp_tuser: [0] busy_res
   logic                  rsp_tuser;
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [QUANTUM_W-1:0]  csr_data   = '0;

   // Side channel that travels with each request beat: a typed expectation.
   logic       row_typed = 1'b0;
   result_type row_want  = '0;

   // Receiver stall control.
   logic rsp_idling = 1'b0;
   int   stall_left = 0;

   // Scheduler shadow state, owned by the monitor.
   logic [QUANTUM_W-1:0] quantum_m;
   logic [ID_W-1:0]      ready_ids [NUM_JOBS];
   logic [SVC_W-1:0]     left_time [NUM_JOBS];
   int                   pend_head;
   int                   pend_count;
   logic [ID_W-1:0]      run_job;
   logic                 run_valid;
   logic [SLICE_W-1:0]   slice_len;

   result_type tick_results_due [$];
   result_type rsp_seen, rsp_want, tick_out;
   int         mismatch_count = 0;

   // Directed table: reset behavior, zero service, extremes of id and service
   // time, a job finishing mid-slice, a duplicate id whose stale entry pops
   // as idle, and a full ready queue dropping the last arrival.
   stim_row_type directed_rows [0:23] = '{
      '{REQ_TICK,   3'd0, 8'd0,   1'b1, 1'b0, 3'd0, 1'b0},   // idle after reset
      '{REQ_ARRIVE, 3'd0, 8'd0,   1'b0, 1'b0, 3'd0, 1'b0},   // zero service: drop
      '{REQ_TICK,   3'd0, 8'd0,   1'b1, 1'b0, 3'd0, 1'b0},   // still idle
      '{REQ_ARRIVE, 3'd7, 8'd255, 1'b0, 1'b0, 3'd0, 1'b0},
      '{REQ_ARRIVE, 3'd1, 8'd1,   1'b0, 1'b0, 3'd0, 1'b0},
      '{REQ_TICK,   3'd0, 8'd0,   1'b1, 1'b1, 3'd7, 1'b0},
      '{REQ_TICK,   3'd0, 8'd0,   1'b1, 1'b1, 3'd7, 1'b0},
      '{REQ_TICK,   3'd0, 8'd0,   1'b1, 1'b1, 3'd1, 1'b1},   // 7 requeued, 1 done
      '{REQ_TICK,   3'd0, 8'd0,   1'b1, 1'b1, 3'd7, 1'b0},
      '{REQ_ARRIVE, 3'd2, 8'd3,   1'b0, 1'b0, 3'd0, 1'b0},
      '{REQ_ARRIVE, 3'd2, 8'd1,   1'b0, 1'b0, 3'd0, 1'b0},   // duplicate id
      '{REQ_TICK,   3'd0, 8'd0,   1'b1, 1'b1, 3'd7, 1'b0},
      '{REQ_TICK,   3'd0, 8'd0,   1'b1, 1'b1, 3'd2, 1'b1},
      '{REQ_TICK,   3'd0, 8'd0,   1'b1, 1'b0, 3'd0, 1'b0},   // stale entry: idle
      '{REQ_ARRIVE, 3'd0, 8'd5,   1'b0, 1'b0, 3'd0, 1'b0},
      '{REQ_ARRIVE, 3'd1, 8'd4,   1'b0, 1'b0, 3'd0, 1'b0},
      '{REQ_ARRIVE, 3'd2, 8'd3,   1'b0, 1'b0, 3'd0, 1'b0},
      '{REQ_ARRIVE, 3'd3, 8'd6,   1'b0, 1'b0, 3'd0, 1'b0},
      '{REQ_ARRIVE, 3'd4, 8'd128, 1'b0, 1'b0, 3'd0, 1'b0},
      '{REQ_ARRIVE, 3'd5, 8'd2,   1'b0, 1'b0, 3'd0, 1'b0},
      '{REQ_ARRIVE, 3'd6, 8'd1,   1'b0, 1'b0, 3'd0, 1'b0},   // queue now full
      '{REQ_ARRIVE, 3'd7, 8'd9,   1'b0, 1'b0, 3'd0, 1'b0},   // full: drop
      '{REQ_TICK,   3'd0, 8'd0,   1'b0, 1'b0, 3'd0, 1'b0},
      '{REQ_TICK,   3'd0, 8'd0,   1'b0, 1'b0, 3'd0, 1'b0}
   };

   round_robin_scheduler #(
      .NUM_JOBS(NUM_JOBS)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #10 clock = ~clock;

   // Hard stop well past the slowest legal run.
   initial begin
      #5_000_000;
      $display("round_robin_scheduler verification failed");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Scheduler shadow: ready queue, per-job time left and the running slice
   // ---------------------------------------------------------------------

   // Append an id at the tail; a full queue drops it.
   function automatic void push_ready(logic [ID_W-1:0] id);
      if (pend_count < NUM_JOBS) begin
         ready_ids[(pend_head + pend_count) % NUM_JOBS] = id;
         pend_count++;
      end
   endfunction

   function automatic logic [ID_W-1:0] pop_ready();
      logic [ID_W-1:0] id;
      id         = ready_ids[pend_head];
      pend_head  = (pend_head + 1) % NUM_JOBS;
      pend_count--;
      return id;
   endfunction

   // Arrival: record service time and enqueue, unless zero, out of range or full.
   function automatic void admit_job(logic [ID_W-1:0] id, logic [SVC_W-1:0] svc);
      if (svc != 0 && id < NUM_JOBS && pend_count < NUM_JOBS) begin
         left_time[id] = svc;
         push_ready(id);
      end
   endfunction

   // One time unit: work out who runs and what the result beat carries.
   function automatic result_type run_one_tick();
      result_type      r;
      logic [ID_W-1:0] nxt;
      r = '0;
      // Slice boundary: nothing running, or the quantum is used up. A zero
      // quantum lands here every tick.
      if (!run_valid || slice_len >= quantum_m) begin
         if (run_valid) begin
            // Requeue the running job behind the arrivals, then take the head;
            // with nobody waiting, the same job simply starts a new slice.
            if (pend_count != 0) begin
               nxt = pop_ready();
               push_ready(run_job);
               run_job = nxt;
            end
         end else begin
            if (pend_count == 0)
               return r;
            run_job = pop_ready();
         end
         slice_len = '0;
         run_valid = 1'b1;
         // A duplicate entry whose shared counter already ran out: idle tick.
         if (left_time[run_job] == 0) begin
            run_valid = 1'b0;
            return r;
         end
      end
      left_time[run_job] = left_time[run_job] - 1'b1;
      if (slice_len != SLICE_MAX)
         slice_len = slice_len + 1'b1;
      r.busy = 1'b1;
      r.job  = run_job;
      if (left_time[run_job] == 0) begin
         r.done    = 1'b1;
         run_valid = 1'b0;
      end
      return r;
   endfunction

   task automatic note_mismatch(input string what, input result_type want,
                                input result_type got);
      mismatch_count++;
      if (mismatch_count <= MAX_SHOWN)
         $display("%0t: %0s: expected busy=%0b job=%0d done=%0b, got busy=%0b job=%0d done=%0b",
                  $realtime, what, want.busy, want.job, want.done,
                  got.busy, got.job, got.done);
   endtask

   // ---------------------------------------------------------------------
   // Monitor: sample every handshake at the rising edge, pre-edge values
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         quantum_m  = DEF_QUANTUM;
         pend_head  = 0;
         pend_count = 0;
         run_job    = '0;
         run_valid  = 1'b0;
         slice_len  = '0;
         tick_results_due.delete();
      end else begin
         if (csr_valid && csr_ready)
            quantum_m = csr_data;

         // Check result beats before predicting: a beat accepted now belongs
         // to an older tick.
         if (rsp_tvalid && rsp_tready) begin
            rsp_seen.busy = rsp_tuser;
            rsp_seen.job  = rsp_tdata[ID_W-1:0];
            rsp_seen.done = rsp_tdata[ID_W];
            if (tick_results_due.size() == 0) begin
               note_mismatch("result beat with no tick pending", '0, rsp_seen);
            end else begin
               rsp_want = tick_results_due.pop_front();
               if (rsp_seen.busy !== rsp_want.busy || rsp_seen.job !== rsp_want.job ||
                   rsp_seen.done !== rsp_want.done)
                  note_mismatch("result beat", rsp_want, rsp_seen);
            end
         end

         if (req_tvalid && req_tready) begin
            if (req_tuser == REQ_TICK) begin
               tick_out = run_one_tick();
               // Rows with a typed expectation override the shadow's answer.
               if (row_typed)
                  tick_out = row_want;
               tick_results_due.push_back(tick_out);
            end else begin
               admit_job(req_tdata[ID_W-1:0], req_tdata[ID_W+SVC_W-1:ID_W]);
            end
         end
      end
   end

   // Receiver: drop rsp_tready in random stall bursts while idling is enabled.
   always @(posedge clock) begin
      if (reset || !rsp_idling) begin
         rsp_tready <= 1'b1;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 7) == 0) begin
         rsp_tready <= 1'b0;
         stall_left <= $urandom_range(0, 11);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // ---------------------------------------------------------------------
   // Sender
   // ---------------------------------------------------------------------

   // Present one request beat and hold it until accepted. Handshake values
   // are read at the falling edge, where they are settled for the next rise.
   task automatic send_beat(input req_kind_type kind, input logic [ID_W-1:0] id,
                            input logic [SVC_W-1:0] svc, input logic typed,
                            input result_type want);
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {{(REQ_DATA_W - SVC_W - ID_W){1'b0}}, svc, id};
      row_typed  <= typed;
      row_want   <= want;
      @(negedge clock);
      while (!req_tready)
         @(negedge clock);
      @(posedge clock);
   endtask

   // Drop valid and wait out a gap.
   task automatic hold_off(input int cycles);
      req_tvalid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Drain every pending result, then give a trailing arrival time to land.
   task automatic settle_idle();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (tick_results_due.size() != 0)
         @(negedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_quantum(input logic [QUANTUM_W-1:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(negedge clock);
      while (!csr_ready)
         @(negedge clock);
      @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   // One phase: drain, set the quantum, then stream random arrivals and
   // ticks. Arrival density and idling are rerolled every 40 beats so that
   // some stretches overload the queue and others leave it empty.
   task automatic random_phase(input logic [QUANTUM_W-1:0] quantum, input int beats,
                               input logic calm);
      int                n;
      int                pick;
      int                arrive_pct;
      logic              gaps_on;
      req_kind_type      kind;
      logic [ID_W-1:0]   id;
      logic [SVC_W-1:0]  svc;
      arrive_pct = 30;
      gaps_on    = 1'b0;
      settle_idle();
      write_quantum(quantum);
      for (n = 0; n < beats; n++) begin
         if (n % 40 == 0) begin
            arrive_pct = $urandom_range(10, 50);
            gaps_on    = !calm && ($urandom_range(0, 2) != 0);
            rsp_idling <= gaps_on;
         end
         if (gaps_on && $urandom_range(0, 4) == 0)
            hold_off($urandom_range(1, 12));
         id  = ID_W'($urandom_range(0, NUM_JOBS - 1));
         svc = '0;
         if ($urandom_range(0, 99) < arrive_pct) begin
            kind = REQ_ARRIVE;
            pick = $urandom_range(0, 99);
            // Mostly short jobs; now and then zero or a long one.
            if (pick < 6)
               svc = '0;
            else if (pick < 10)
               svc = SVC_W'($urandom_range(11, 255));
            else
               svc = SVC_W'($urandom_range(1, 10));
         end else begin
            kind = REQ_TICK;
            // Noise on the ignored fields of a tick.
            if ($urandom_range(0, 3) == 0)
               svc = SVC_W'($urandom_range(0, 255));
         end
         send_beat(kind, id, svc, 1'b0, '0);
      end
   endtask

   initial begin
      int         r;
      result_type want;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part at the reset quantum.
      for (r = 0; r < 24; r++) begin
         want.busy = directed_rows[r].want_busy;
         want.job  = directed_rows[r].want_job;
         want.done = directed_rows[r].want_done;
         send_beat(directed_rows[r].kind, directed_rows[r].job_id, directed_rows[r].svc,
                   directed_rows[r].typed, want);
      end

      // Random part. The largest quantum first leaves a job mid-slice, so the
      // drop to one ends that slice on the next tick; zero acts as one.
      random_phase(8'd255, 146, 1'b0);
      random_phase(8'd1,   146, 1'b0);
      random_phase(8'd0,   146, 1'b0);
      random_phase(QUANTUM_W'($urandom_range(3, 20)),   146, 1'b0);
      random_phase(QUANTUM_W'($urandom_range(21, 254)), 146, 1'b0);
      // Close at full rate on both sides with the reset quantum.
      random_phase(DEF_QUANTUM, 146, 1'b1);

      settle_idle();
      repeat (4) @(posedge clock);
      if (mismatch_count == 0 && tick_results_due.size() == 0)
         $display("round_robin_scheduler verification clean");
      else
         $display("round_robin_scheduler verification failed");
      $finish;
   end

endmodule
